FILE: rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the clamped PID controller: field widths,
// register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int DATA_WIDTH_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int SETPOINT_W  = 16;
  localparam int GAIN_W      = 16;
  localparam int MAX_OUT_W   = 15;
  localparam int INT_LIM_W   = 24;
  localparam int ACC_W       = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [MAX_OUT_W-1:0] MAX_OUTPUT_RST = '1;
  localparam logic [INT_LIM_W-1:0] ACC_LIMIT_RST  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_MAX_OUTPUT = 3'd4,
    REG_ACC_LIMIT  = 3'd5
  } pidc_reg_t;

  typedef struct packed {
    logic signed [SETPOINT_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]     gain_p;
    logic signed [GAIN_W-1:0]     gain_i;
    logic signed [GAIN_W-1:0]     gain_d;
    logic [MAX_OUT_W-1:0]         max_output;
    logic [INT_LIM_W-1:0]         acc_limit;
  } pidc_cfg_t;

endpackage

FILE: rtl/pidc_in_if.sv
// ----------------------------------------------------------------------------
// pidc_in_if
// Measurement channel: one signed sample per beat.
// ----------------------------------------------------------------------------
interface pidc_in_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measure;

  modport source (output valid, output measure, input ready);
  modport sink   (input valid, input measure, output ready);
endinterface

FILE: rtl/pidc_out_if.sv
// ----------------------------------------------------------------------------
// pidc_out_if
// Drive channel: one clamped controller output per beat.
// ----------------------------------------------------------------------------
interface pidc_out_if #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

FILE: rtl/pidc_cfg_if.sv
// ----------------------------------------------------------------------------
// pidc_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface pidc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pidc_pkg::CFG_IDX_W-1:0]   index;
  logic [pidc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pidc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Configuration register file: setpoint, gains and the two symmetric limits.
// ----------------------------------------------------------------------------
module pidc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  pidc_cfg_if.sink             cfg_ch,
  output pidc_pkg::pidc_cfg_t  cfg
);

  pidc_pkg::pidc_cfg_t cfg_r;
  pidc_pkg::pidc_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      // unknown indexes drop the beat
      unique case (cfg_ch.index)
        pidc_pkg::REG_SETPOINT:       cfg_nxt.setpoint   = cfg_ch.data[pidc_pkg::SETPOINT_W-1:0];
        pidc_pkg::REG_GAIN_P:         cfg_nxt.gain_p     = cfg_ch.data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_GAIN_I:         cfg_nxt.gain_i     = cfg_ch.data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_GAIN_D:         cfg_nxt.gain_d     = cfg_ch.data[pidc_pkg::GAIN_W-1:0];
        pidc_pkg::REG_MAX_OUTPUT:     cfg_nxt.max_output = cfg_ch.data[pidc_pkg::MAX_OUT_W-1:0];
        pidc_pkg::REG_ACC_LIMIT: begin
          cfg_nxt.acc_limit = cfg_ch.data[pidc_pkg::INT_LIM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= '0;
      cfg_r.gain_p     <= '0;
      cfg_r.gain_i     <= '0;
      cfg_r.gain_d     <= '0;
      cfg_r.max_output <= pidc_pkg::MAX_OUTPUT_RST;
      cfg_r.acc_limit  <= pidc_pkg::ACC_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Positional PID controller with anti-windup clamp on the error sum and a
// symmetric clamp on the drive.
// ----------------------------------------------------------------------------
// The block takes one measurement per cycle while the output is not stalled,
// and returns one drive value per measurement, in order. Five register stages
// carry each sample: input register, error, accumulator and difference, the
// three gain products, and the summed, floor-shifted and clamped drive. The
// accumulator and previous error are updated as a sample enters the third
// stage, so back-to-back samples see each other's state. Each stage advances
// whenever the next one is empty or moving, so bubbles close up under output
// back-pressure. Registers are written through the cfg channel, which is
// always ready; write them only while no sample is in flight.
module pid_controller_clamped #(
  parameter int DATA_WIDTH     = pidc_pkg::DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pidc_in_if.sink    in_ch,
  pidc_out_if.source out_ch,
  pidc_cfg_if.sink   cfg_ch
);

  localparam int EW   = ((DATA_WIDTH > pidc_pkg::SETPOINT_W) ?
                         DATA_WIDTH : pidc_pkg::SETPOINT_W) + 1;
  localparam int DFW  = EW + 1;
  localparam int AW   = pidc_pkg::ACC_W;
  localparam int ASW  = ((EW > AW) ? EW : AW) + 1;
  localparam int PPW  = pidc_pkg::GAIN_W + EW;
  localparam int PIW  = pidc_pkg::GAIN_W + AW;
  localparam int PDW  = pidc_pkg::GAIN_W + DFW;
  localparam int SW   = ((DFW > AW) ? DFW : AW) + pidc_pkg::GAIN_W + 2;

  pidc_pkg::pidc_cfg_t cfg;

  pidc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  // stage payloads
  logic signed [DATA_WIDTH-1:0] meas1_r;
  logic signed [EW-1:0]         err2_r;
  logic signed [EW-1:0]         err2_nxt;
  logic signed [EW-1:0]         prev_err_r;
  logic signed [AW-1:0]         acc_r;
  logic signed [AW-1:0]         acc_nxt;
  logic signed [ASW-1:0]        acc_sum;
  logic signed [ASW-1:0]        acc_lim;
  logic signed [DFW-1:0]        diff_nxt;
  logic signed [EW-1:0]         err3_r;
  logic signed [AW-1:0]         acc3_r;
  logic signed [DFW-1:0]        diff3_r;
  logic signed [PPW-1:0]        pp_nxt, pp4_r;
  logic signed [PIW-1:0]        pi_nxt, pi4_r;
  logic signed [PDW-1:0]        pd_nxt, pd4_r;
  logic signed [SW-1:0]         sum;
  logic signed [SW-1:0]         sum_sh;
  logic signed [SW-1:0]         out_lim;
  logic signed [SW-1:0]         drive_full;
  logic signed [DATA_WIDTH-1:0] drive_r;

  // error
  assign err2_nxt = EW'(cfg.setpoint) - EW'(meas1_r);

  // accumulator with anti-windup clamp, and error difference
  always_comb begin
    acc_sum  = ASW'(acc_r) + ASW'(err2_r);
    acc_lim  = ASW'($signed({1'b0, cfg.acc_limit}));
    diff_nxt = DFW'(err2_r) - DFW'(prev_err_r);
    priority if (acc_sum > acc_lim) begin
      acc_nxt = AW'(acc_lim);
    end else if (acc_sum < -acc_lim) begin
      acc_nxt = AW'(-acc_lim);
    end else begin
      acc_nxt = AW'(acc_sum);
    end
  end

  // gain products
  assign pp_nxt = PPW'(cfg.gain_p) * PPW'(err3_r);
  assign pi_nxt = PIW'(cfg.gain_i) * PIW'(acc3_r);
  assign pd_nxt = PDW'(cfg.gain_d) * PDW'(diff3_r);

  // sum, floor shift, output clamp
  always_comb begin
    sum     = SW'(pp4_r) + SW'(pi4_r) + SW'(pd4_r);
    sum_sh  = sum >>> GAIN_FRAC_BITS;
    out_lim = SW'($signed({1'b0, cfg.max_output}));
    priority if (sum_sh > out_lim) begin
      drive_full = out_lim;
    end else if (sum_sh < -out_lim) begin
      drive_full = -out_lim;
    end else begin
      drive_full = sum_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      prev_err_r <= '0;
      acc_r      <= '0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      // state advances once per sample, as it enters stage three
      if (en3 && v2_r) begin
        prev_err_r <= err2_r;
        acc_r      <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) meas1_r <= in_ch.measure;
    if (en2) err2_r  <= err2_nxt;
    if (en3) begin
      err3_r  <= err2_r;
      acc3_r  <= acc_nxt;
      diff3_r <= diff_nxt;
    end
    if (en4) begin
      pp4_r <= pp_nxt;
      pi4_r <= pi_nxt;
      pd4_r <= pd_nxt;
    end
    if (en5) drive_r <= drive_full[DATA_WIDTH-1:0];
  end

  assign out_ch.valid = v5_r;
  assign out_ch.drive = drive_r;

endmodule
